### hw/rtl/itrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_pkg
// Shared types and constants for the integer to radix string converter.
// ----------------------------------------------------------------------------
package itrs_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

  // configuration reset values: radix 10, alphabet "0123456789"
  localparam logic [4:0]  SYMBOL_COUNT_RST = 5'd10;
  localparam logic [63:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

  // characters
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // divider status toward the controller
  typedef struct packed {
    logic done;
    logic quot_zero;
  } div_stat_t;

endpackage

### hw/rtl/itrs_alpha.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_alpha
// Checks the configured digit alphabet: count range, forbidden symbols and
// duplicate symbols.
// ----------------------------------------------------------------------------
module itrs_alpha #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic [4:0]   symbol_count,
  input  logic [127:0] symbols,
  output logic         ok
);
  import itrs_pkg::*;

  always_comb begin
    logic [7:0] c;
    ok = (symbol_count >= 5'd2) && (symbol_count <= 5'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      c = symbols[i*8 +: 8];
      if (symbol_count > 5'(i)) begin
        if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE ||
            (c >= CHAR_TAB && c <= CHAR_CR)) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (symbol_count > 5'(j) && symbols[j*8 +: 8] == c) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

endmodule

### hw/rtl/itrs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrs_div
// Bit-serial restoring divider: one dividend bit per cycle, gives quotient
// and remainder by a small radix after VALUE_BITS steps.
// ----------------------------------------------------------------------------
module itrs_div #(
  parameter int VALUE_BITS = 32,
  parameter int RADIX_W    = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   dividend,
  input  logic [RADIX_W-1:0]      radix,
  output itrs_pkg::div_stat_t     stat,
  output logic [VALUE_BITS-1:0]   quotient,
  output logic [RADIX_W-2:0]      remainder
);
  import itrs_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] q;
  logic [RADIX_W-2:0]    rem;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [RADIX_W-1:0]    trial;
  logic [RADIX_W-1:0]    diff;
  logic                  fits;
  logic [RADIX_W-2:0]    rem_next;

  assign trial    = {rem, q[VALUE_BITS-1]};
  assign fits     = trial >= radix;
  assign diff     = trial - radix;
  assign rem_next = fits ? diff[RADIX_W-2:0] : trial[RADIX_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[VALUE_BITS-2:0], fits};
      rem <= rem_next;
    end
  end

  assign stat.done      = done;
  assign stat.quot_zero = (q == '0);
  assign quotient       = q;
  assign remainder      = rem;

endmodule

### hw/rtl/int_to_radix_string.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_radix_string
// Converts a signed integer to text in the radix of a configured symbol
// alphabet, most significant digit first, with a leading '-' for negatives.
//
//   channel  signals                          direction
//   cfg      cfg_we, cfg_index, cfg_data      in, write only
//   in       in_valid, in_ready, value        in
//   out      out_valid, out_ready, text_char,  out, one transaction per char
//            is_last
//
// Each digit is one full pass of the bit-serial divider; once all digits
// are found, characters leave one per cycle while the output is not stalled.
// Reset loads radix 10 with alphabet "0123456789". A stalled output holds
// its character; the next value is taken once the last character of the
// previous one is registered.
// ----------------------------------------------------------------------------
module int_to_radix_string #(
  parameter int MAX_SYMBOLS = 16,
  parameter int VALUE_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [31:0] value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        text_char,
  output logic              is_last
);
  import itrs_pkg::*;

  localparam int DIG_W   = $clog2(MAX_SYMBOLS);
  localparam int RADIX_W = DIG_W + 1;
  localparam int STACK_W = VALUE_BITS * DIG_W;
  localparam int NDIG_W  = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_SIGN  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;

  logic [4:0]  symbol_count;
  logic [63:0] symbols_low;
  logic [63:0] symbols_high;

  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [STACK_W-1:0]    stack;
  logic [NDIG_W-1:0]     ndig;

  logic                  alpha_ok;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-2:0]    div_rem;

  logic                  out_free;
  logic [VALUE_BITS-1:0] raw;
  logic [127:0]          symbols;
  logic [DIG_W-1:0]      top_digit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= SYMBOL_COUNT_RST;
      symbols_low  <= SYMBOLS_LOW_RST;
      symbols_high <= SYMBOLS_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYMBOL_COUNT: symbol_count <= cfg_data[4:0];
        REG_SYMBOLS_LOW:  symbols_low  <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign symbols = {symbols_high, symbols_low};

  itrs_alpha #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_alpha (
    .symbol_count(symbol_count),
    .symbols     (symbols),
    .ok          (alpha_ok)
  );

  assign div_start    = (state == S_CHECK && alpha_ok) ||
                        (state == S_DIV && div_stat.done && !div_stat.quot_zero);
  assign div_dividend = (state == S_DIV) ? div_quot : mag;

  itrs_div #(
    .VALUE_BITS(VALUE_BITS),
    .RADIX_W   (RADIX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (symbol_count[RADIX_W-1:0]),
    .stat     (div_stat),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign raw       = value[VALUE_BITS-1:0];
  assign top_digit = stack[DIG_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_SIGN || state == S_EMIT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= alpha_ok ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_stat.done && div_stat.quot_zero) begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (ndig == NDIG_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          neg  <= raw[VALUE_BITS-1];
          mag  <= raw[VALUE_BITS-1] ? (~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : raw;
          ndig <= '0;
        end
      end
      S_CHECK: ;
      S_DIV: begin
        if (div_stat.done) begin
          stack <= {stack[STACK_W-DIG_W-1:0], div_rem[DIG_W-1:0]};
          ndig  <= ndig + 1'b1;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          text_char <= CHAR_MINUS;
          is_last   <= 1'b0;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          text_char <= symbols[top_digit*8 +: 8];
          is_last   <= (ndig == NDIG_W'(1));
          stack     <= {{DIG_W{1'b0}}, stack[STACK_W-1:DIG_W]};
          ndig      <= ndig - 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### tb/sv/int_to_radix_string_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_radix_string_tb
// Self-checking bench for the integer to radix string converter. Values are
// sent through a valid/ready driver with random gaps, and characters are
// taken by a monitor with random stalls. The monitor checks every character
// and its last flag against text predicted from the bench's copy of the
// alphabet registers. The run walks through radix 10, 2 and 16, alphabets
// broken by bad counts, duplicates and reserved characters, and many random
// alphabets. Registers are only rewritten once the converter has drained.
// ----------------------------------------------------------------------------
module int_to_radix_string_tb;
  import itrs_pkg::*;

  localparam int DRAIN_CYCLES = 1200;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  typedef enum int {FLAW_NONE, FLAW_DUP, FLAW_CHAR} flaw_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         text_char;
  logic               is_last;

  // bench copy of the alphabet registers
  logic [4:0]  radix_cfg = SYMBOL_COUNT_RST;
  logic [63:0] sym_lo = SYMBOLS_LOW_RST;
  logic [63:0] sym_hi = SYMBOLS_HIGH_RST;

  logic [31:0] pending_values [$];
  text_beat_t  expected_text [$];
  text_beat_t  got_beat;
  int          error_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;

  int_to_radix_string DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .text_char (text_char),
    .is_last   (is_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit bad_symbol(input logic [7:0] c);
    return c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE ||
           (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic logic [7:0] symbol_at(input int unsigned i);
    logic [63:0] w;
    w = (i < 8) ? sym_lo : sym_hi;
    return w[8 * (i % 8) +: 8];
  endfunction

  function automatic bit alphabet_ok();
    int unsigned n;
    int unsigned i;
    int unsigned j;
    n = 32'(radix_cfg);
    if (n < 2 || n > 16) return 1'b0;
    for (i = 0; i < n; i++) begin
      if (bad_symbol(symbol_at(i))) return 1'b0;
      for (j = i + 1; j < n; j++)
        if (symbol_at(j) == symbol_at(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic [31:0] v);
    logic [31:0] mag;
    logic [31:0] rdx;
    int unsigned digits [$];
    bit          neg;
    int          k;
    if (!alphabet_ok()) return;
    rdx = 32'(radix_cfg);
    neg = v[31];
    mag = neg ? ~v + 32'd1 : v;
    do begin
      digits.push_front(mag % rdx);
      mag = mag / rdx;
    end while (mag != 0);
    if (neg) expected_text.push_back('{ch: CHAR_MINUS, last: 1'b0});
    for (k = 0; k < digits.size(); k++)
      expected_text.push_back('{ch: symbol_at(digits[k]), last: k == digits.size() - 1});
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 15) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 3) v = $urandom();
    else if (r < 5) v = $urandom_range(0, 300);
    else if (r == 5) v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
    else if (r == 6) v = $urandom_range(0, 65535);
    else v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if ($urandom_range(0, 1) == 1) v = ~v + 32'd1;
    return v;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // transaction driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) predict_text(value);
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_values.size() != 0) begin
          value <= pending_values.pop_front();
          in_valid <= 1'b1;
          in_gap = steady_in ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // transaction monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          note_error($sformatf("unexpected char, expected none actual %h last %b",
                               text_char, is_last));
        end else begin
          got_beat = expected_text.pop_front();
          if (text_char !== got_beat.ch)
            note_error($sformatf("text_char mismatch, expected %h actual %h",
                                 got_beat.ch, text_char));
          if (is_last !== got_beat.last)
            note_error($sformatf("is_last mismatch, expected %b actual %b",
                                 got_beat.last, is_last));
        end
      end
      if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = steady_out ? 0 : pick_gap();
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_values.size() != 0 || in_valid || expected_text.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SYMBOL_COUNT: radix_cfg = data[4:0];
      REG_SYMBOLS_LOW: sym_lo = data;
      default: sym_hi = data;
    endcase
  endtask

  task automatic apply_setting(input logic [63:0] count_word, input logic [63:0] lo,
                               input logic [63:0] hi);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_SYMBOL_COUNT, count_word);
    write_reg(REG_SYMBOLS_LOW, lo);
    write_reg(REG_SYMBOLS_HIGH, hi);
    @(posedge clk);
    cfg_we <= 1'b0;
    steady_in = ($urandom_range(0, 3) == 0);
    steady_out = ($urandom_range(0, 3) == 0);
  endtask

  task automatic make_alphabet(input int unsigned n, input flaw_t flaw,
                               input logic [7:0] bad_char,
                               output logic [63:0] lo, output logic [63:0] hi);
    logic [7:0]  syms [16];
    logic [7:0]  c;
    int unsigned i;
    int unsigned j;
    bit          clash;
    for (i = 0; i < 16; i++) syms[i] = 8'($urandom_range(0, 255));
    for (i = 0; i < n && i < 16; i++) begin
      do begin
        c = 8'($urandom_range(0, 255));
        clash = bad_symbol(c);
        for (j = 0; j < i; j++)
          if (syms[j] == c) clash = 1'b1;
      end while (clash);
      syms[i] = c;
    end
    if (flaw == FLAW_DUP) begin
      i = $urandom_range(1, n - 1);
      syms[i] = syms[$urandom_range(0, i - 1)];
    end else if (flaw == FLAW_CHAR) begin
      syms[$urandom_range(0, n - 1)] = bad_char;
    end
    for (i = 0; i < 8; i++) begin
      lo[8 * i +: 8] = syms[i];
      hi[8 * i +: 8] = syms[i + 8];
    end
  endtask

  task automatic push_random(input int unsigned n_items);
    repeat (n_items) pending_values.push_back(random_value());
  endtask

  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] count_word;
    logic [7:0]  bad_list [$];
    logic [4:0]  bad_counts [4];
    int unsigned n;
    int unsigned r;
    int unsigned p;
    flaw_t       flaw;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // radix 10 from reset
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(-32'sd10);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'd1_000_000_000);
    wait_drained();
    push_random(20);

    // binary, longest text
    apply_setting(64'd2, 64'h3130, {$urandom(), $urandom()});
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'd5);
    push_random(8);

    // hex, full alphabet
    apply_setting(64'd16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'hDEAD_BEEF);
    pending_values.push_back(32'd15);
    pending_values.push_back(32'd16);
    push_random(20);

    // counts outside the legal range
    bad_counts = '{5'd0, 5'd1, 5'd17, 5'd31};
    foreach (bad_counts[k]) begin
      make_alphabet(16, FLAW_NONE, CHAR_NUL, lo, hi);
      count_word = {$urandom(), $urandom()};
      count_word[4:0] = bad_counts[k];
      apply_setting(count_word, lo, hi);
      push_random(2);
    end

    // reserved characters inside the alphabet
    bad_list = '{CHAR_NUL, CHAR_SPACE, CHAR_PLUS, CHAR_MINUS};
    for (p = CHAR_TAB; p <= CHAR_CR; p++) bad_list.push_back(8'(p));
    foreach (bad_list[k]) begin
      n = $urandom_range(2, 16);
      make_alphabet(n, FLAW_CHAR, bad_list[k], lo, hi);
      apply_setting(64'(n), lo, hi);
      push_random(2);
    end

    // repeated symbol
    make_alphabet(16, FLAW_DUP, CHAR_NUL, lo, hi);
    apply_setting(64'd16, lo, hi);
    push_random(2);

    // random alphabets
    repeat (10) begin
      r = $urandom_range(0, 4);
      n = (r == 0) ? 2 : (r == 1) ? 16 : $urandom_range(3, 15);
      r = $urandom_range(0, 9);
      flaw = (r == 0) ? FLAW_DUP : (r == 1) ? FLAW_CHAR : FLAW_NONE;
      make_alphabet(n, flaw, bad_list[$urandom_range(0, bad_list.size() - 1)], lo, hi);
      count_word = $urandom_range(0, 1) ? {$urandom(), $urandom()} : 64'd0;
      count_word[4:0] = 5'(n);
      apply_setting(count_word, lo, hi);
      push_random(20);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/itrs_pkg.sv
hw/rtl/itrs_alpha.sv
hw/rtl/itrs_div.sv
hw/rtl/int_to_radix_string.sv
tb/sv/int_to_radix_string_tb.sv
